[sv/bhte_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bhte_pkg;
  localparam int unsigned DefCapacity  = 16;
  localparam int unsigned DefValueBits = 16;
  localparam int unsigned ModeBits     = 3;
  localparam int unsigned KeyBits      = 16;
  localparam int unsigned PosBits      = 4;
  localparam int unsigned StatusBits   = 2;

  localparam logic [ModeBits-1:0] ModeAppend = 3'd0;
  localparam logic [ModeBits-1:0] ModeBuild  = 3'd1;
  localparam logic [ModeBits-1:0] ModeDelete = 3'd2;
  localparam logic [ModeBits-1:0] ModeSearch = 3'd3;
  localparam logic [ModeBits-1:0] ModeRead   = 3'd4;

  localparam logic [StatusBits-1:0] StOk       = 2'd0;
  localparam logic [StatusBits-1:0] StNotFound = 2'd1;
  localparam logic [StatusBits-1:0] StFull     = 2'd2;
  localparam logic [StatusBits-1:0] StRange    = 2'd3;
endpackage
`default_nettype wire

[sv/binary_heap_table_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// Binary heap engine: holds up to CAPACITY values in one single-port synchronous
// memory laid out as a binary heap, in max order (order 0, written through
// cfg_we_i/cfg_wdata_i) or min order (order 1). Command tdata = {mode, key_value,
// position} from bit 0, zero padded; result tdata = {status, found, read_value,
// count} from bit 0. One command at a time; the next command is taken only after
// the result transfer. Append and no-op modes go from the command straight to the
// result; an in-range read passes a read-wait step first. Search and delete scan
// the entries in turn, each in three steps (issue read, wait, compare). A build or
// delete rebuild sifts each inner node down: each level visited takes the steps
// read parent, read left, read right, compare right (only where a right child
// exists) and decide, plus a second write step for a swap; a leaf ends at the
// read-parent step. The steps are serial since all accesses share one memory port.
module binary_heap_table_engine #(
  parameter int unsigned CAPACITY   = bhte_pkg::DefCapacity,
  parameter int unsigned VALUE_BITS = bhte_pkg::DefValueBits
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // mode[2:0], key_value[18:3], position[22:19], zero pad
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[1:0], found[2], read_value[18:3], count[23:19]
  output logic [23:0]      m_axis_tdata
);
  import bhte_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RDWAIT = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_SCANW  = 4'd3;
  localparam logic [3:0] S_DELRD  = 4'd4;
  localparam logic [3:0] S_DELWR  = 4'd5;
  localparam logic [3:0] S_BNODE  = 4'd6;
  localparam logic [3:0] S_RDP    = 4'd7;
  localparam logic [3:0] S_RDL    = 4'd8;
  localparam logic [3:0] S_RDR    = 4'd9;
  localparam logic [3:0] S_CMPR   = 4'd10;
  localparam logic [3:0] S_DECIDE = 4'd11;
  localparam logic [3:0] S_SWAP2  = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [VALUE_BITS-1:0] mem [CAPACITY];
  logic                  mwe;
  logic [AW-1:0]         maddr;
  logic [VALUE_BITS-1:0] mwdata, mrdata_q;

  logic [3:0]            state_q, state_d;
  logic                  order_q;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [ModeBits-1:0]   mode_q, mode_d;
  logic [VALUE_BITS-1:0] key_q, key_d;
  logic [CW-1:0]         idx_q, idx_d;     // scan index / build node counter
  logic [CW:0]           node_q, node_d;   // sift position (wide for child math)
  logic [CW:0]           best_q, best_d;
  logic [VALUE_BITS-1:0] pv_q, pv_d, bv_q, bv_d;
  logic [StatusBits-1:0] st_q, st_d;
  logic                  fnd_q, fnd_d;
  logic [VALUE_BITS-1:0] rv_q, rv_d;
  logic                  ov_q, ov_d;

  logic [ModeBits-1:0]   in_mode;
  logic [VALUE_BITS-1:0] in_key;
  logic [PosBits-1:0]    in_pos;
  logic [CW:0]           lch, rch;
  logic                  above;

  assign in_mode = s_axis_tdata[2:0];
  assign in_key  = VALUE_BITS'(s_axis_tdata[18:3]);
  assign in_pos  = s_axis_tdata[22:19];
  assign lch = {node_q[CW-1:0], 1'b1};
  assign rch = lch + 1'b1;
  // memory data ranks above current best in configured order
  assign above = order_q ? (mrdata_q < bv_q) : (mrdata_q > bv_q);

  assign s_axis_tready = (state_q == S_IDLE) && !ov_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {5'(cnt_q), 16'(rv_q), fnd_q, st_q};

  // store
  always_ff @(posedge clk_i) begin
    if (mwe) mem[maddr] <= mwdata;
    mrdata_q <= mem[maddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      order_q <= 1'b0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      if (cfg_we_i) order_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d; key_q <= key_d; idx_q <= idx_d; node_q <= node_d;
    best_q <= best_d; pv_q <= pv_d; bv_q <= bv_d;
    st_q <= st_d; fnd_q <= fnd_d; rv_q <= rv_d;
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; ov_d = ov_q;
    mode_d = mode_q; key_d = key_q; idx_d = idx_q; node_d = node_q;
    best_d = best_q; pv_d = pv_q; bv_d = bv_q;
    st_d = st_q; fnd_d = fnd_q; rv_d = rv_q;
    mwe = 1'b0; maddr = '0; mwdata = key_q;
    if (m_axis_tready) ov_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          mode_d = in_mode; key_d = in_key;
          st_d = StOk; fnd_d = 1'b0; rv_d = '0;
          idx_d = '0;
          case (in_mode)
            ModeAppend: begin
              if (cnt_q >= CapC) st_d = StFull;
              else begin
                mwe = 1'b1; maddr = AW'(cnt_q); mwdata = in_key;
                cnt_d = cnt_q + 1'b1;
              end
              state_d = S_DONE;
            end
            ModeBuild: begin
              idx_d = cnt_q >> 1;
              state_d = S_BNODE;
            end
            ModeDelete, ModeSearch: state_d = S_SCAN;
            ModeRead: begin
              if (32'(in_pos) >= 32'(cnt_q)) begin
                st_d = StRange; state_d = S_DONE;
              end else begin
                maddr = AW'(in_pos); state_d = S_RDWAIT;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      // read data for the requested position is valid now
      S_RDWAIT: begin rv_d = mrdata_q; state_d = S_DONE; end
      // linear search: issue read of idx
      S_SCAN: begin
        if (idx_q >= cnt_q) begin st_d = StNotFound; state_d = S_DONE; end
        else begin maddr = AW'(idx_q); state_d = S_SCANW; end
      end
      // hold the scan address so the data stays valid for the compare
      S_SCANW: begin
        maddr = AW'(idx_q);
        state_d = S_DELRD;
      end
      S_DELRD: begin
        // data for idx now in mrdata_q
        if (mrdata_q == key_q) begin
          fnd_d = 1'b1;
          if (mode_q == ModeDelete) begin
            maddr = AW'(cnt_q - 1'b1); state_d = S_DELWR;
          end else state_d = S_DONE;
        end else begin
          idx_d = idx_q + 1'b1; state_d = S_SCAN;
        end
      end
      S_DELWR: begin
        // hold the last-entry address; move it into matched slot next
        maddr = AW'(cnt_q - 1'b1);
        state_d = S_SWAP2;
        best_d = '1;
      end
      S_BNODE: begin
        if (idx_q == '0) state_d = S_DONE;
        else begin
          idx_d = idx_q - 1'b1;
          node_d = (CW+1)'(idx_q - 1'b1);
          state_d = S_RDP;
        end
      end
      S_RDP: begin
        maddr = AW'(node_q); state_d = S_RDL;
        if (lch >= (CW+1)'(cnt_q)) state_d = S_BNODE;
      end
      S_RDL: begin
        // parent data valid now
        pv_d = mrdata_q; bv_d = mrdata_q; best_d = node_q;
        maddr = AW'(lch); state_d = S_RDR;
      end
      S_RDR: begin
        // left child data valid now
        if (above) begin bv_d = mrdata_q; best_d = lch; end
        maddr = AW'(rch);
        if (rch < (CW+1)'(cnt_q)) state_d = S_CMPR;
        else state_d = S_DECIDE;
      end
      S_CMPR: begin
        // right child data valid now
        if (above) begin bv_d = mrdata_q; best_d = rch; end
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (best_q == node_q) state_d = S_BNODE;
        else begin
          mwe = 1'b1; maddr = AW'(node_q); mwdata = bv_q;
          state_d = S_SWAP2;
        end
      end
      S_SWAP2: begin
        if (best_q == '1) begin
          // delete move: mrdata_q holds the last entry
          mwe = 1'b1; maddr = AW'(idx_q); mwdata = mrdata_q;
          cnt_d = cnt_q - 1'b1;
          idx_d = (cnt_q - 1'b1) >> 1;
          state_d = S_BNODE;
        end else begin
          mwe = 1'b1; maddr = AW'(best_q); mwdata = pv_q;
          node_d = best_q;
          state_d = S_RDP;
        end
      end
      S_DONE: begin
        if (!ov_q || m_axis_tready) begin ov_d = 1'b1; state_d = S_IDLE; end
      end
      default: state_d = S_IDLE;
    endcase
  end

  ap_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CapC) else $error("count above capacity");
  ap_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
  ap_cnt_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !(s_axis_tvalid && s_axis_tready)) |=> $stable(cnt_q))
    else $error("count moved while idle");
endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
module tb;
  import bhte_pkg::*;

  localparam int Cap = 16;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // mode[2:0], key_value[18:3], position[22:19], zero pad
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // status[1:0], found[2], read_value[18:3], count[23:19]
  logic [23:0] m_axis_tdata;

  typedef struct packed {
    logic [4:0]  count;
    logic [15:0] read_value;
    logic        found;
    logic [1:0]  status;
  } heap_result_t;

  binary_heap_table_engine u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Shadow heap state
  logic [15:0]  shadow_store[Cap];
  int           shadow_count = 0;
  logic         shadow_min = 1'b0;
  heap_result_t pending_results[$];
  heap_result_t got_res, want_res;
  int           error_count = 0;
  int           idle_cycles = 0;
  bit           hold_sink = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    begin
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      error_count++;
    end
  endtask

  function automatic bit outranks(input logic [15:0] a, input logic [15:0] b);
    return shadow_min ? (a < b) : (a > b);
  endfunction

  function automatic void rebuild_heap();
    int node, best, l, r;
    logic [15:0] t;
    for (int i = shadow_count / 2 - 1; i >= 0; i--) begin
      node = i;
      forever begin
        best = node;
        l = 2 * node + 1;
        r = 2 * node + 2;
        if (l < shadow_count && outranks(shadow_store[l], shadow_store[best])) best = l;
        if (r < shadow_count && outranks(shadow_store[r], shadow_store[best])) best = r;
        if (best == node) break;
        t = shadow_store[node];
        shadow_store[node] = shadow_store[best];
        shadow_store[best] = t;
        node = best;
      end
    end
  endfunction

  function automatic heap_result_t apply_command(input logic [2:0] mode,
                                                 input logic [15:0] key,
                                                 input logic [3:0] pos);
    heap_result_t res;
    int i;
    res = '0;
    case (mode)
      ModeAppend: begin
        if (shadow_count >= Cap) res.status = StFull;
        else begin
          shadow_store[shadow_count] = key;
          shadow_count++;
        end
      end
      ModeBuild: rebuild_heap();
      ModeDelete, ModeSearch: begin
        for (i = 0; i < shadow_count; i++) if (shadow_store[i] == key) break;
        if (i >= shadow_count) res.status = StNotFound;
        else begin
          res.found = 1'b1;
          if (mode == ModeDelete) begin
            shadow_store[i] = shadow_store[shadow_count - 1];
            shadow_count--;
            rebuild_heap();
          end
        end
      end
      ModeRead: begin
        if (int'(pos) >= shadow_count) res.status = StRange;
        else res.read_value = shadow_store[pos];
      end
      default: ;
    endcase
    res.count = 5'(shadow_count);
    return res;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one command and hold it until the transfer
  task automatic send_command(input logic [2:0] mode, input logic [15:0] key,
                              input logic [3:0] pos);
    int gap;
    heap_result_t exp_res;
    begin
      // start at a later falling edge than the one that dropped the last offer
      gap = gap_len();
      repeat (gap + 1) @(negedge clk_i);
      s_axis_tdata  <= {1'b0, pos, key, mode};
      s_axis_tvalid <= 1'b1;
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      exp_res = apply_command(mode, key, pos);
      pending_results = {pending_results, exp_res};
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  task automatic drain_results();
    begin
      while (pending_results.size() != 0) @(negedge clk_i);
      repeat (300) @(negedge clk_i);
    end
  endtask

  task automatic write_order(input logic order);
    begin
      drain_results();
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= order;
      @(negedge clk_i);
      cfg_we_i    <= 1'b0;
      shadow_min  = order;
    end
  endtask

  // Sink side: random stalls, or a long hold when requested
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_sink) m_axis_tready <= 1'b0;
      else m_axis_tready <= (gap_len() == 0) || ($urandom_range(0, 2) == 0);
    end
  end

  // Compare each result transfer with the oldest pending one
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      got_res = m_axis_tdata;
      if (pending_results.size() == 0) begin
        report("unexpected result", got_res.read_value, 16'h0);
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.status != want_res.status)
          report("status", 16'(got_res.status), 16'(want_res.status));
        if (got_res.found != want_res.found)
          report("found", 16'(got_res.found), 16'(want_res.found));
        if (got_res.read_value != want_res.read_value)
          report("read_value", got_res.read_value, want_res.read_value);
        if (got_res.count != want_res.count)
          report("count", 16'(got_res.count), 16'(want_res.count));
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("[binary_heap_table_engine] ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    begin
      send_command(ModeBuild, 16'h0, 4'd0);
      send_command(ModeRead, 16'h0, 4'd0);
      send_command(ModeSearch, 16'h5, 4'd0);
      send_command(ModeDelete, 16'h5, 4'd0);
      for (int i = 0; i < 16; i++)
        send_command(ModeAppend, (i == 0) ? 16'h0 : (i == 1) ? 16'hFFFF : 16'(i * 4099 % 7), 4'd0);
      send_command(ModeAppend, 16'h1234, 4'd0);
      send_command(ModeBuild, 16'h0, 4'd0);
      send_command(ModeRead, 16'h0, 4'd15);
      send_command(3'd5, 16'hFFFF, 4'hF);
      send_command(3'd7, 16'h0, 4'h0);
      send_command(ModeDelete, 16'hFFFF, 4'd0);
      send_command(ModeRead, 16'h0, 4'd15);
    end
  endtask

  task automatic test_random(input int n);
    logic [2:0] mode;
    logic [15:0] key;
    int r;
    begin
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(0, 99);
        mode = (r < 30) ? ModeAppend : (r < 42) ? ModeBuild : (r < 60) ? ModeDelete :
               (r < 75) ? ModeSearch : (r < 97) ? ModeRead : 3'($urandom_range(5, 7));
        if ($urandom_range(0, 3) != 0 && shadow_count > 0 && mode != ModeAppend)
          key = shadow_store[$urandom_range(0, shadow_count - 1)];
        else if ($urandom_range(0, 1) == 0) key = 16'($urandom_range(0, 7));
        else key = 16'($urandom);
        send_command(mode, key, 4'($urandom));
      end
    end
  endtask

  // Hold the sink long enough that the block backs up
  task automatic test_backpressure();
    begin
      hold_sink = 1'b1;
      fork
        test_random(6);
        begin
          repeat (600) @(negedge clk_i);
          hold_sink = 1'b0;
        end
      join
      drain_results();
      test_random(20);
    end
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    write_order(1'b1);
    test_directed();
    test_backpressure();
    write_order(1'b0);
    test_random(500);
    write_order(1'b1);
    test_random(550);
    write_order(1'b0);
    test_random(500);
    drain_results();
    if (error_count == 0) $display("[binary_heap_table_engine] OK");
    else $display("[binary_heap_table_engine] ERROR");
    $finish;
  end
endmodule

[sim.f]
sv/bhte_pkg.sv
sv/binary_heap_table_engine.sv
dv/tb.sv
